>>> sv/frg_pkg.sv
package frg_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int NUM_W      = DATA_WIDTH;
  localparam int DEN_W      = DATA_WIDTH - 1;
  localparam int CNT_W      = $clog2(NUM_W + 1);
  localparam int PC_W       = 4;

  typedef logic [NUM_W-1:0]        word_t;
  typedef logic signed [NUM_W-1:0] num_t;
  typedef logic [DEN_W-1:0]        den_t;
  typedef logic [PC_W-1:0]         pc_t;
  typedef logic [1:0]              dsel_t;
  typedef logic [2:0]              jcond_t;

  // divider operand selection
  localparam dsel_t DS_XY = 2'd0;  // x % y
  localparam dsel_t DS_MG = 2'd1;  // |num| / g
  localparam dsel_t DS_DG = 2'd2;  // den / g

  // jump conditions
  localparam jcond_t JC_NONE     = 3'd0;
  localparam jcond_t JC_ALWAYS   = 3'd1;
  localparam jcond_t JC_NO_INPUT = 3'd2;
  localparam jcond_t JC_Y_ZERO   = 3'd3;
  localparam jcond_t JC_DIV_BUSY = 3'd4;
  localparam jcond_t JC_OUT_BUSY = 3'd5;

  // program steps
  localparam pc_t STEP_ACCEPT  = 4'd0;
  localparam pc_t STEP_TEST    = 4'd1;
  localparam pc_t STEP_MOD     = 4'd2;
  localparam pc_t STEP_MOD_END = 4'd3;
  localparam pc_t STEP_LOOP    = 4'd4;
  localparam pc_t STEP_FIX_G   = 4'd5;
  localparam pc_t STEP_DIV_N   = 4'd6;
  localparam pc_t STEP_N_END   = 4'd7;
  localparam pc_t STEP_DIV_D   = 4'd8;
  localparam pc_t STEP_D_END   = 4'd9;
  localparam pc_t STEP_PUBLISH = 4'd10;
  localparam pc_t STEP_RETURN  = 4'd11;

  typedef struct packed {
    logic   in_ready;
    logic   ld_in;
    logic   div_start;
    dsel_t  div_sel;
    logic   swap;
    logic   ld_g;
    logic   ld_num;
    logic   out_write;
    jcond_t jc;
    pc_t    target;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic y_zero;
    logic div_busy;
    logic out_busy;
  } stat_t;

  // Control store. Load, start, swap and write actions of a step take effect only when its jump is not taken.
  // The wait steps keep the divider's operand selection while it iterates.
  function automatic ctrl_t frg_rom(pc_t pc);
    ctrl_t c;
    c = '0;
    case (pc)
      STEP_ACCEPT: begin
        c.in_ready = 1'b1;
        c.ld_in    = 1'b1;
        c.jc       = JC_NO_INPUT;
        c.target   = STEP_ACCEPT;
      end
      STEP_TEST: begin
        c.jc     = JC_Y_ZERO;
        c.target = STEP_FIX_G;
      end
      STEP_MOD: begin
        c.div_start = 1'b1;
        c.div_sel   = DS_XY;
      end
      STEP_MOD_END: begin
        c.div_sel = DS_XY;
        c.swap    = 1'b1;
        c.jc      = JC_DIV_BUSY;
        c.target  = STEP_MOD_END;
      end
      STEP_LOOP: begin
        c.jc     = JC_ALWAYS;
        c.target = STEP_TEST;
      end
      STEP_FIX_G: begin
        c.ld_g = 1'b1;
      end
      STEP_DIV_N: begin
        c.div_start = 1'b1;
        c.div_sel   = DS_MG;
      end
      STEP_N_END: begin
        c.div_sel = DS_MG;
        c.ld_num  = 1'b1;
        c.jc      = JC_DIV_BUSY;
        c.target  = STEP_N_END;
      end
      STEP_DIV_D: begin
        c.div_start = 1'b1;
        c.div_sel   = DS_DG;
      end
      STEP_D_END: begin
        c.div_sel = DS_DG;
        c.jc      = JC_DIV_BUSY;
        c.target  = STEP_D_END;
      end
      STEP_PUBLISH: begin
        c.out_write = 1'b1;
        c.jc        = JC_OUT_BUSY;
        c.target    = STEP_PUBLISH;
      end
      STEP_RETURN: begin
        c.jc     = JC_ALWAYS;
        c.target = STEP_ACCEPT;
      end
      default: begin
        c.jc     = JC_ALWAYS;
        c.target = STEP_ACCEPT;
      end
    endcase
    return c;
  endfunction

endpackage

>>> sv/frg_in_if.sv
interface frg_in_if;
  import frg_pkg::*;

  logic valid;
  logic ready;
  num_t num_in;
  den_t den_in;

  modport source (output valid, num_in, den_in, input ready);
  modport sink   (input valid, num_in, den_in, output ready);
endinterface

>>> sv/frg_out_if.sv
interface frg_out_if;
  import frg_pkg::*;

  logic valid;
  logic ready;
  num_t num_out;
  den_t den_out;

  modport source (output valid, num_out, den_out, input ready);
  modport sink   (input valid, num_out, den_out, output ready);
endinterface

>>> sv/frg_div.sv
module frg_div (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  frg_pkg::word_t dividend,
  input  frg_pkg::word_t divisor,
  output logic           busy,
  output frg_pkg::word_t quot,
  output frg_pkg::word_t rem
);
  import frg_pkg::*;

  logic [CNT_W-1:0] cnt;
  logic [NUM_W:0]   trial;
  logic [NUM_W:0]   diff;
  logic             fits;

  // restoring division, one quotient bit per cycle
  assign trial = {rem, quot[NUM_W-1]};
  assign fits  = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(NUM_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quot <= dividend;
    end else if (busy) begin
      if (fits) begin
        rem  <= diff[NUM_W-1:0];
        quot <= {quot[NUM_W-2:0], 1'b1};
      end else begin
        rem  <= trial[NUM_W-1:0];
        quot <= {quot[NUM_W-2:0], 1'b0};
      end
    end
  end

endmodule

>>> sv/frg_seq.sv
module frg_seq (
  input  logic           clk,
  input  logic           rst,
  input  frg_pkg::stat_t stat,
  output frg_pkg::ctrl_t ctrl
);
  import frg_pkg::*;

  pc_t   pc;
  pc_t   pc_next;
  ctrl_t word;
  logic  taken;

  assign word = frg_rom(pc);

  always_comb begin
    case (word.jc)
      JC_NONE:     taken = 1'b0;
      JC_ALWAYS:   taken = 1'b1;
      JC_NO_INPUT: taken = !stat.in_valid;
      JC_Y_ZERO:   taken = stat.y_zero;
      JC_DIV_BUSY: taken = stat.div_busy;
      JC_OUT_BUSY: taken = stat.out_busy;
      default:     taken = 1'b0;
    endcase
  end

  always_comb begin
    ctrl = word;
    if (taken) begin
      ctrl.ld_in     = 1'b0;
      ctrl.div_start = 1'b0;
      ctrl.swap      = 1'b0;
      ctrl.ld_g      = 1'b0;
      ctrl.ld_num    = 1'b0;
      ctrl.out_write = 1'b0;
    end
    pc_next = taken ? word.target : pc + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= STEP_ACCEPT;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

>>> sv/fraction_reduce_gcd.sv
// channel  dir  payload                          transfer when
// req      in   num_in (32b signed), den_in (31b) valid && ready
// rsp      out  num_out (32b signed), den_out (31b) valid && ready
//
// One item at a time. The accept step loads the item; each Euclid remainder step then
// runs on the bit-serial divider, and the two final quotients |num|/g and den/g
// follow on the same divider. There are no remainder steps when den_in is zero.
// Synchronous reset returns the sequencer to its accept step and drops rsp valid.
// The result register frees the input side: a new item is taken while rsp stalls.
module fraction_reduce_gcd (
  input logic      clk,
  input logic      rst,
  frg_in_if.sink   req,
  frg_out_if.source rsp
);
  import frg_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  word_t num_raw;
  word_t mag_in;
  logic  neg;
  word_t mag;
  den_t  den;
  word_t x;
  word_t y;
  word_t g;
  word_t qn;
  num_t  res_num;
  den_t  res_den;
  logic  out_valid;

  word_t div_a;
  word_t div_b;
  logic  div_busy;
  word_t div_quot;
  word_t div_rem;

  frg_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctrl (ctrl)
  );

  frg_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (ctrl.div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .busy     (div_busy),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  assign num_raw = word_t'(req.num_in);
  assign mag_in  = num_raw[NUM_W-1] ? (~num_raw + 1'b1) : num_raw;

  always_comb begin
    case (ctrl.div_sel)
      DS_XY: begin
        div_a = x;
        div_b = y;
      end
      DS_MG: begin
        div_a = mag;
        div_b = g;
      end
      DS_DG: begin
        div_a = {1'b0, den};
        div_b = g;
      end
      default: begin
        div_a = x;
        div_b = y;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld_in) begin
      neg <= num_raw[NUM_W-1];
      mag <= mag_in;
      den <= req.den_in;
      x   <= mag_in;
      y   <= {1'b0, req.den_in};
    end else if (ctrl.swap) begin
      x <= y;
      y <= div_rem;
    end
    if (ctrl.ld_g) begin
      // zero gcd only for 0/0
      g <= (x == '0) ? word_t'(1) : x;
    end
    if (ctrl.ld_num) begin
      qn <= neg ? (~div_quot + 1'b1) : div_quot;
    end
    if (ctrl.out_write) begin
      res_num <= num_t'(qn);
      res_den <= div_quot[DEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.out_write) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign stat.in_valid = req.valid;
  assign stat.y_zero   = (y == '0);
  assign stat.div_busy = div_busy;
  assign stat.out_busy = out_valid & ~rsp.ready;

  assign req.ready   = ctrl.in_ready;
  assign rsp.valid   = out_valid;
  assign rsp.num_out = res_num;
  assign rsp.den_out = res_den;

endmodule
